// ===== hw/rtl/dpalu_pkg.sv =====
package dpalu_pkg;

   localparam int unsigned DATA_WIDTH = 32;

   typedef enum logic [3:0] {
      ACT_AND = 4'd0,
      ACT_EOR = 4'd1,
      ACT_SUB = 4'd2,
      ACT_RSB = 4'd3,
      ACT_ADD = 4'd4,
      ACT_ADC = 4'd5,
      ACT_SBC = 4'd6,
      ACT_RSC = 4'd7,
      ACT_TST = 4'd8,
      ACT_TEQ = 4'd9,
      ACT_CMP = 4'd10,
      ACT_CMN = 4'd11,
      ACT_ORR = 4'd12,
      ACT_MOV = 4'd13,
      ACT_BIC = 4'd14,
      ACT_MVN = 4'd15
   } action_type;

   // Function unit that produces the result; inversions are folded into the operands.
   typedef enum logic [2:0] {
      UNIT_AND,
      UNIT_EOR,
      UNIT_ORR,
      UNIT_MOV,
      UNIT_ADD
   } unit_type;

   typedef struct packed {
      unit_type unit;
      logic     write_result;
      logic     update;
      logic     restore;
      logic     shifter_carry;
      logic     negative;
      logic     zero;
      logic     carry;
      logic     overflow;
   } ctrl_type;

endpackage

// ===== hw/rtl/dpalu_exec.sv =====
module dpalu_exec (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  dpalu_pkg::ctrl_type                 in_ctrl,
   input  logic [dpalu_pkg::DATA_WIDTH-1:0]    in_opa,
   input  logic [dpalu_pkg::DATA_WIDTH-1:0]    in_opb,
   input  logic                                in_cin,
   output logic                                out_valid,
   output dpalu_pkg::ctrl_type                 out_ctrl,
   output logic [dpalu_pkg::DATA_WIDTH-1:0]    out_result,
   output logic                                out_carry,
   output logic                                out_overflow
);

   logic [dpalu_pkg::DATA_WIDTH:0]   sum_wide;
   logic [dpalu_pkg::DATA_WIDTH-1:0] sum;
   logic                             add_ovf;

   logic                             valid_ff;
   dpalu_pkg::ctrl_type              ctrl_ff;
   logic [dpalu_pkg::DATA_WIDTH-1:0] result_ff, result_in;
   logic                             carry_ff, carry_in;
   logic                             overflow_ff, overflow_in;

   assign sum_wide = {1'b0, in_opa} + {1'b0, in_opb}
                     + {{dpalu_pkg::DATA_WIDTH{1'b0}}, in_cin};
   assign sum      = sum_wide[dpalu_pkg::DATA_WIDTH-1:0];
   assign add_ovf  = (in_opa[dpalu_pkg::DATA_WIDTH-1] ^ sum[dpalu_pkg::DATA_WIDTH-1])
                   & (in_opb[dpalu_pkg::DATA_WIDTH-1] ^ sum[dpalu_pkg::DATA_WIDTH-1]);

   always_comb begin
      // Logical operations take C from the shifter and keep V.
      carry_in    = in_ctrl.shifter_carry;
      overflow_in = in_ctrl.overflow;
      case (in_ctrl.unit)
         dpalu_pkg::UNIT_AND: result_in = in_opa & in_opb;
         dpalu_pkg::UNIT_EOR: result_in = in_opa ^ in_opb;
         dpalu_pkg::UNIT_ORR: result_in = in_opa | in_opb;
         dpalu_pkg::UNIT_MOV: result_in = in_opb;
         dpalu_pkg::UNIT_ADD: begin
            result_in   = sum;
            carry_in    = sum_wide[dpalu_pkg::DATA_WIDTH];
            overflow_in = add_ovf;
         end
         default: result_in = in_opb;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff     <= in_ctrl;
      result_ff   <= result_in;
      carry_ff    <= carry_in;
      overflow_ff <= overflow_in;
   end

   assign out_valid    = valid_ff;
   assign out_ctrl     = ctrl_ff;
   assign out_result   = result_ff;
   assign out_carry    = carry_ff;
   assign out_overflow = overflow_ff;

endmodule

// ===== hw/rtl/data_processing_alu_unit.sv =====
// Channel   Direction  Handshake                 Fields
// request   in         start & !busy             action, operands, shifter carry, NZCV, S, PC
// response  out        rsp_strobe, one cycle     result, write flag, NZCV, restore status
//
// Three register stages: operand decode, adder or logic unit, flag selection.
// An accepted item passes the operand, execute and flag registers in turn to rsp_strobe; one item per clock.
// busy is never raised: items are independent and the response cannot stall.
// Synchronous reset clears the stage valid bits; payload registers are not reset.
module data_processing_alu_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [3:0]                       req_action,
   input  logic [dpalu_pkg::DATA_WIDTH-1:0] req_operand_first,
   input  logic [dpalu_pkg::DATA_WIDTH-1:0] req_operand_second,
   input  logic                             req_shifter_carry,
   input  logic                             req_carry_in,
   input  logic                             req_overflow_in,
   input  logic                             req_negative_in,
   input  logic                             req_zero_in,
   input  logic                             req_set_flags,
   input  logic                             req_dest_is_pc,
   output logic                             rsp_strobe,
   output logic [dpalu_pkg::DATA_WIDTH-1:0] rsp_result_value,
   output logic                             rsp_write_result,
   output logic                             rsp_negative_out,
   output logic                             rsp_zero_out,
   output logic                             rsp_carry_out,
   output logic                             rsp_overflow_out,
   output logic                             rsp_restore_status
);

   logic                             accept;
   dpalu_pkg::ctrl_type              ctrl_in;
   logic [dpalu_pkg::DATA_WIDTH-1:0] opa_in, opb_in;
   logic                             cin_in;

   logic                             s1_valid_ff;
   dpalu_pkg::ctrl_type              s1_ctrl_ff;
   logic [dpalu_pkg::DATA_WIDTH-1:0] s1_opa_ff, s1_opb_ff;
   logic                             s1_cin_ff;

   logic                             s2_valid;
   dpalu_pkg::ctrl_type              s2_ctrl;
   logic [dpalu_pkg::DATA_WIDTH-1:0] s2_result;
   logic                             s2_carry, s2_overflow;

   logic                             s3_valid_ff;
   logic [dpalu_pkg::DATA_WIDTH-1:0] s3_result_ff;
   logic                             s3_write_ff, s3_restore_ff;
   logic                             s3_n_ff, s3_z_ff, s3_c_ff, s3_v_ff;
   logic                             s3_n_in, s3_z_in, s3_c_in, s3_v_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stage 1: pick the function unit and its operands, fold inversions in.
   always_comb begin
      ctrl_in.unit          = dpalu_pkg::UNIT_ADD;
      ctrl_in.write_result  = 1'b1;
      ctrl_in.update        = req_set_flags & ~req_dest_is_pc;
      ctrl_in.restore       = req_set_flags & req_dest_is_pc;
      ctrl_in.shifter_carry = req_shifter_carry;
      ctrl_in.negative      = req_negative_in;
      ctrl_in.zero          = req_zero_in;
      ctrl_in.carry         = req_carry_in;
      ctrl_in.overflow      = req_overflow_in;
      opa_in                = req_operand_first;
      opb_in                = req_operand_second;
      cin_in                = 1'b0;
      unique case (dpalu_pkg::action_type'(req_action)) inside
         dpalu_pkg::ACT_AND, dpalu_pkg::ACT_TST: ctrl_in.unit = dpalu_pkg::UNIT_AND;
         dpalu_pkg::ACT_EOR, dpalu_pkg::ACT_TEQ: ctrl_in.unit = dpalu_pkg::UNIT_EOR;
         dpalu_pkg::ACT_SUB, dpalu_pkg::ACT_CMP: begin
            opb_in = ~req_operand_second;
            cin_in = 1'b1;
         end
         dpalu_pkg::ACT_RSB: begin
            opa_in = req_operand_second;
            opb_in = ~req_operand_first;
            cin_in = 1'b1;
         end
         dpalu_pkg::ACT_ADD, dpalu_pkg::ACT_CMN: cin_in = 1'b0;
         dpalu_pkg::ACT_ADC: cin_in = req_carry_in;
         dpalu_pkg::ACT_SBC: begin
            opb_in = ~req_operand_second;
            cin_in = req_carry_in;
         end
         dpalu_pkg::ACT_RSC: begin
            opa_in = req_operand_second;
            opb_in = ~req_operand_first;
            cin_in = req_carry_in;
         end
         dpalu_pkg::ACT_ORR: ctrl_in.unit = dpalu_pkg::UNIT_ORR;
         dpalu_pkg::ACT_MOV: ctrl_in.unit = dpalu_pkg::UNIT_MOV;
         dpalu_pkg::ACT_BIC: begin
            ctrl_in.unit = dpalu_pkg::UNIT_AND;
            opb_in       = ~req_operand_second;
         end
         dpalu_pkg::ACT_MVN: begin
            ctrl_in.unit = dpalu_pkg::UNIT_MOV;
            opb_in       = ~req_operand_second;
         end
         default: ctrl_in.unit = dpalu_pkg::UNIT_ADD;
      endcase
      // Compare and test actions drop the register write.
      case (dpalu_pkg::action_type'(req_action)) inside
         dpalu_pkg::ACT_TST, dpalu_pkg::ACT_TEQ,
         dpalu_pkg::ACT_CMP, dpalu_pkg::ACT_CMN: ctrl_in.write_result = 1'b0;
         default: ctrl_in.write_result = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff <= ctrl_in;
      s1_opa_ff  <= opa_in;
      s1_opb_ff  <= opb_in;
      s1_cin_ff  <= cin_in;
   end

   // Stage 2: adder and logic unit.
   dpalu_exec u_exec (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_ctrl      (s1_ctrl_ff),
      .in_opa       (s1_opa_ff),
      .in_opb       (s1_opb_ff),
      .in_cin       (s1_cin_ff),
      .out_valid    (s2_valid),
      .out_ctrl     (s2_ctrl),
      .out_result   (s2_result),
      .out_carry    (s2_carry),
      .out_overflow (s2_overflow)
   );

   // Stage 3: N and Z, then keep the old flags unless an update is due.
   always_comb begin
      if (s2_ctrl.update) begin
         s3_n_in = s2_result[dpalu_pkg::DATA_WIDTH-1];
         s3_z_in = (s2_result == '0);
         s3_c_in = s2_carry;
         s3_v_in = s2_overflow;
      end else begin
         s3_n_in = s2_ctrl.negative;
         s3_z_in = s2_ctrl.zero;
         s3_c_in = s2_ctrl.carry;
         s3_v_in = s2_ctrl.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_result_ff  <= s2_result;
      s3_write_ff   <= s2_ctrl.write_result;
      s3_restore_ff <= s2_ctrl.restore;
      s3_n_ff       <= s3_n_in;
      s3_z_ff       <= s3_z_in;
      s3_c_ff       <= s3_c_in;
      s3_v_ff       <= s3_v_in;
   end

   assign rsp_strobe         = s3_valid_ff;
   assign rsp_result_value   = s3_result_ff;
   assign rsp_write_result   = s3_write_ff;
   assign rsp_negative_out   = s3_n_ff;
   assign rsp_zero_out       = s3_z_ff;
   assign rsp_carry_out      = s3_c_ff;
   assign rsp_overflow_out   = s3_v_ff;
   assign rsp_restore_status = s3_restore_ff;

endmodule
